### hw/rtl/mblur_pkg.sv
// ----------------------------------------------------------------------------
// mblur_pkg
// Shared constants and types for the motion blur line filter.
// ----------------------------------------------------------------------------
package mblur_pkg;

    localparam int MAX_BLUR_DEF = 16;
    localparam int PIX_W        = 8;
    localparam int BLUR_W       = 5;
    localparam int LANES        = 3;

    localparam logic [BLUR_W-1:0] BLUR_RESET = 5'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } mblur_div_stat_t;

endpackage

### hw/rtl/motion_blur_line_filter.sv
// ----------------------------------------------------------------------------
// motion_blur_line_filter
// Horizontal box motion blur along a line, blended half and half with source.
// ----------------------------------------------------------------------------
// Flow: a pixel accepted in ST_IDLE is summed in ST_SUM over its window,
//   read from the history newest first, divided by n + 1 in ST_DIV by the
//   bit-serial divider and blended in ST_OUT once the output register is free,
//   n being min(blur_amount, MAX_BLUR, line pixels). s_ready is high only in
//   ST_IDLE, so no new pixel is taken until the last result has been loaded.
// Reset: synchronous, active low; blur_amount returns to 4, window emptied.
// ----------------------------------------------------------------------------
module motion_blur_line_filter
    import mblur_pkg::*;
#(
    parameter int MAX_BLUR = MAX_BLUR_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration word: blur_amount
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BLUR_W-1:0] cfg_data,
    // pixel in
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PIX_W-1:0]  s_red,
    input  logic [PIX_W-1:0]  s_green,
    input  logic [PIX_W-1:0]  s_blue,
    input  logic              s_line_start,
    // pixel out
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_red_out,
    output logic [PIX_W-1:0]  m_green_out,
    output logic [PIX_W-1:0]  m_blue_out
);

    localparam int CNT_W = $clog2(MAX_BLUR + 1);
    localparam int PTR_W = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
    localparam int SUM_W = $clog2(MAX_BLUR * 255 + 1);
    localparam int DVS_W = $clog2(MAX_BLUR + 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_BLUR - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [BLUR_W-1:0]           blur_reg, blur_next;
    logic [PTR_W-1:0]            wp_reg, wp_next;
    logic [PTR_W-1:0]            rp_reg, rp_next;
    logic [CNT_W-1:0]            wc_reg, wc_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            left_reg, left_next;
    logic                        pend_reg, pend_next;
    logic [LANES-1:0][SUM_W-1:0] sum_reg, sum_next;
    logic [3*PIX_W-1:0]          pix_reg, pix_next;
    logic                        m_valid_reg, m_valid_next;
    logic [3*PIX_W-1:0]          res_reg, res_next;

    logic                        in_fire;
    logic                        out_load;
    logic [PTR_W-1:0]            wp_eff;
    logic [CNT_W-1:0]            wc_eff;
    logic [CNT_W-1:0]            blur_clamp;
    logic                        rd_en;
    logic [3*PIX_W-1:0]          rd_data;
    logic                        hist_wr;
    logic                        div_start;
    logic [LANES-1:0][SUM_W-1:0] quo;
    mblur_div_stat_t             div_stat;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;

    // a line start empties the window before this pixel is looked at
    assign wp_eff = s_line_start ? '0 : wp_reg;
    assign wc_eff = s_line_start ? '0 : wc_reg;

    // oversized blur amounts fold down to the history depth
    assign blur_clamp = (blur_reg > MAX_BLUR) ? CNT_W'(MAX_BLUR) : CNT_W'(blur_reg);

    // read one history entry a cycle, newest first
    assign rd_en = (state_reg == ST_SUM) && (left_reg != '0);

    // sums complete once every read has been issued and its data added
    assign div_start = (state_reg == ST_SUM) && (left_reg == '0) && !pend_reg;

    // store the current pixel as the sums are handed to the divider
    assign hist_wr = div_start;

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        blur_next    = blur_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        wc_next      = wc_reg;
        n_next       = n_reg;
        left_next    = left_reg;
        pend_next    = 1'b0;
        sum_next     = sum_reg;
        pix_next     = pix_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;

        if (cfg_valid && cfg_ready) begin
            blur_next = cfg_data;
        end

        // drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    pix_next   = {s_red, s_green, s_blue};
                    wp_next    = wp_eff;
                    wc_next    = wc_eff;
                    n_next     = (blur_clamp < wc_eff) ? blur_clamp : wc_eff;
                    left_next  = (blur_clamp < wc_eff) ? blur_clamp : wc_eff;
                    rp_next    = (wp_eff == '0) ? PTR_LAST : wp_eff - 1'b1;
                    sum_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (rd_en) begin
                    rp_next   = (rp_reg == '0) ? PTR_LAST : rp_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    sum_next[2] = sum_reg[2] + SUM_W'(rd_data[3*PIX_W-1:2*PIX_W]);
                    sum_next[1] = sum_reg[1] + SUM_W'(rd_data[2*PIX_W-1:PIX_W]);
                    sum_next[0] = sum_reg[0] + SUM_W'(rd_data[PIX_W-1:0]);
                end
                if (div_start) begin
                    wp_next    = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    wc_next    = (wc_reg < MAX_BLUR) ? wc_reg + 1'b1 : wc_reg;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free, then blend
                if (out_load) begin
                    res_next[3*PIX_W-1:2*PIX_W] = {1'b0, pix_reg[3*PIX_W-1:2*PIX_W+1]}
                                                  + {1'b0, quo[2][PIX_W-1:1]};
                    res_next[2*PIX_W-1:PIX_W]   = {1'b0, pix_reg[2*PIX_W-1:PIX_W+1]}
                                                  + {1'b0, quo[1][PIX_W-1:1]};
                    res_next[PIX_W-1:0]         = {1'b0, pix_reg[PIX_W-1:1]}
                                                  + {1'b0, quo[0][PIX_W-1:1]};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rp_reg   <= rp_next;
        n_reg    <= n_next;
        left_reg <= left_next;
        pix_reg  <= pix_next;
        res_reg  <= res_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            blur_reg    <= BLUR_RESET;
            wp_reg      <= '0;
            wc_reg      <= '0;
            pend_reg    <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            blur_reg    <= blur_next;
            wp_reg      <= wp_next;
            wc_reg      <= wc_next;
            pend_reg    <= pend_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    mblur_hist #(
        .MAX_BLUR (MAX_BLUR),
        .PTR_W    (PTR_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_wr),
        .wr_addr (wp_reg),
        .wr_data (pix_reg),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    mblur_div #(
        .SUM_W (SUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (DVS_W'(n_reg) + DVS_W'(1)),
        .dividend (sum_reg),
        .quotient (quo),
        .stat     (div_stat)
    );

    assign m_valid     = m_valid_reg;
    assign m_red_out   = res_reg[3*PIX_W-1:2*PIX_W];
    assign m_green_out = res_reg[2*PIX_W-1:PIX_W];
    assign m_blue_out  = res_reg[PIX_W-1:0];

    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (n_reg <= wc_reg) && (left_reg <= n_reg))
        else $error("window exceeds pixels held for the line");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wc_reg <= MAX_BLUR)
        else $error("window count beyond history depth");

    a_accept_to_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_SUM) && !pend_reg)
        else $error("accepted pixel did not start summing");

endmodule

### hw/rtl/mblur_hist.sv
// ----------------------------------------------------------------------------
// mblur_hist
// Ring store of recent pixels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mblur_hist
    import mblur_pkg::*;
#(
    parameter int MAX_BLUR = MAX_BLUR_DEF,
    parameter int PTR_W    = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [PTR_W-1:0]       wr_addr,
    input  logic [3*PIX_W-1:0]     wr_data,
    input  logic                   rd_en,
    input  logic [PTR_W-1:0]       rd_addr,
    output logic [3*PIX_W-1:0]     rd_data
);

    logic [3*PIX_W-1:0] mem [MAX_BLUR];
    logic [3*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/mblur_div.sv
// ----------------------------------------------------------------------------
// mblur_div
// Restoring divider, one quotient bit per cycle, three lanes on one divisor.
// ----------------------------------------------------------------------------
module mblur_div
    import mblur_pkg::*;
#(
    parameter int SUM_W = 12,
    parameter int DVS_W = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [DVS_W-1:0]             divisor,
    input  logic [LANES-1:0][SUM_W-1:0]  dividend,
    output logic [LANES-1:0][SUM_W-1:0]  quotient,
    output mblur_div_stat_t              stat
);

    localparam int ITW = $clog2(SUM_W + 1);

    logic [LANES-1:0][SUM_W-1:0] quo_reg, quo_next;
    logic [LANES-1:0][DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0]            dvs_reg;
    logic [ITW-1:0]              cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DVS_W:0]              trial [LANES];

    // one restoring step on each lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_reg[l], quo_reg[l][SUM_W-1]};
            if (trial[l] >= {1'b0, dvs_reg}) begin
                rem_next[l] = DVS_W'(trial[l] - {1'b0, dvs_reg});
                quo_next[l] = {quo_reg[l][SUM_W-2:0], 1'b1};
            end else begin
                rem_next[l] = DVS_W'(trial[l]);
                quo_next[l] = {quo_reg[l][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= ITW'(SUM_W);
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == ITW'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == ITW'(1))) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motion blur line filter.
// Pixels stream in under changing flow control. An in-bench model of the blur
// window predicts every output word, and each word is checked in arrival order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mblur_pkg::*;

    localparam int unsigned WIN_MAX        = MAX_BLUR_DEF;
    localparam int unsigned SEGS_PER_PHASE = 4;
    localparam int unsigned WORDS_PER_SEG  = 116;   // pixels per segment, over 4 phases x 4 segments
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned END_SETTLE     = 40;    // idle wait after the final drain, in clock cycles
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             line_start;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    // How a random line is shaded: anything, channels at the rails, or a
    // narrow band around one colour.
    typedef enum logic [1:0] {
        TONE_ANY,
        TONE_RAIL,
        TONE_NEAR
    } tone_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [BLUR_W-1:0] cfg_data     = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [PIX_W-1:0]  s_red        = '0;
    logic [PIX_W-1:0]  s_green      = '0;
    logic [PIX_W-1:0]  s_blue       = '0;
    logic              s_line_start = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [PIX_W-1:0]  m_red_out;
    logic [PIX_W-1:0]  m_green_out;
    logic [PIX_W-1:0]  m_blue_out;

    motion_blur_line_filter #(
        .MAX_BLUR(WIN_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_line_start(s_line_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Blur window model: its own copy of the register, ring and line fill
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] hist_r [WIN_MAX];
    logic [PIX_W-1:0] hist_g [WIN_MAX];
    logic [PIX_W-1:0] hist_b [WIN_MAX];
    int unsigned      ring_wr      = 0;
    int unsigned      line_fill    = 0;
    int unsigned      blur_setting = BLUR_RESET;

    rgb_t             blurred_q [$];    // predicted words, oldest first

    // Bookkeeping for the closing summary and verdict
    int unsigned      fail_cnt      = 0;
    int unsigned      words_checked = 0;
    int unsigned      pixels_sent   = 0;
    int unsigned      lines_sent    = 0;
    int unsigned      cfg_writes    = 0;

    // Flow control knobs, in percent
    int unsigned      src_idle_pct  = 0;
    int unsigned      snk_stall_pct = 0;

    // Output hold-off: the test side bumps the request count, the stall
    // process serves it and counts the cycles down on its own.
    int unsigned      holdoff_asked = 0;
    int unsigned      holdoff_taken = 0;
    int unsigned      holdoff_left  = 0;

    // Half the source plus half of the window sum divided by n + 1, all floored.
    function automatic logic [PIX_W-1:0] half_mix(input logic [PIX_W-1:0] orig,
                                                  input int unsigned sum,
                                                  input int unsigned n);
        int unsigned mix;
        mix = orig / 2 + (sum / (n + 1)) / 2;
        return PIX_W'(mix);
    endfunction

    function automatic rgb_t blur_predict(input pix_in_t px);
        int unsigned n;
        int unsigned k;
        int unsigned slot;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        rgb_t        res;
        // A flagged pixel empties the window before it is blended
        if (px.line_start) begin
            line_fill = 0;
            ring_wr   = 0;
        end
        // Clamp an oversized setting, then to what this line has kept so far
        n = (blur_setting > WIN_MAX) ? WIN_MAX : blur_setting;
        if (n > line_fill) begin
            n = line_fill;
        end
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (k = 1; k <= n; k++) begin
            slot   = (ring_wr + WIN_MAX - k) % WIN_MAX;
            sum_r += hist_r[slot];
            sum_g += hist_g[slot];
            sum_b += hist_b[slot];
        end
        res.red   = half_mix(px.red,   sum_r, n);
        res.green = half_mix(px.green, sum_g, n);
        res.blue  = half_mix(px.blue,  sum_b, n);
        // Push the current pixel behind the window
        hist_r[ring_wr] = px.red;
        hist_g[ring_wr] = px.green;
        hist_b[ring_wr] = px.blue;
        ring_wr = (ring_wr + 1) % WIN_MAX;
        if (line_fill < WIN_MAX) begin
            line_fill++;
        end
        return res;
    endfunction

    function automatic pix_in_t shade(input tone_t tone, input logic [23:0] base);
        pix_in_t px;
        px.line_start = 1'b0;
        case (tone)
            TONE_RAIL: begin
                px.red   = $urandom_range(1) ? '1 : '0;
                px.green = $urandom_range(1) ? '1 : '0;
                px.blue  = $urandom_range(1) ? '1 : '0;
            end
            TONE_NEAR: begin
                px.red   = base[23:16] + PIX_W'($urandom_range(6)) - PIX_W'(3);
                px.green = base[15:8]  + PIX_W'($urandom_range(6)) - PIX_W'(3);
                px.blue  = base[7:0]   + PIX_W'($urandom_range(6)) - PIX_W'(3);
            end
            default: begin
                px.red   = PIX_W'($urandom);
                px.green = PIX_W'($urandom);
                px.blue  = PIX_W'($urandom);
            end
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, served hold-offs, and the word checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1;
            m_ready <= 1'b0;
        end else if (holdoff_taken != holdoff_asked) begin
            holdoff_taken = holdoff_taken + 1;
            holdoff_left  = HOLDOFF_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each accepted word against the oldest prediction
    always @(posedge aclk) begin : check_words
        rgb_t got;
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_red_out, m_green_out, m_blue_out};
            words_checked++;
            if (blurred_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS) begin
                    $display("%0t: unexpected output word rgb %0d/%0d/%0d",
                             $time, got.red, got.green, got.blue);
                end
            end else begin
                want = blurred_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("%0t: mismatch, expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offer one pixel word, hold it until taken, then record its prediction.
    // Valid stays high on return so back-to-back words need no re-raise.
    task automatic send_pixel(input pix_in_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_red        <= px.red;
        s_green      <= px.green;
        s_blue       <= px.blue;
        s_line_start <= px.line_start;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        blurred_q.push_back(blur_predict(px));
        pixels_sent++;
    endtask

    // Drop valid and hold the input until every predicted word has come out
    task automatic drain_words();
        s_valid <= 1'b0;
        while (blurred_q.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // Only ever called with the pixel channel drained
    task automatic write_blur(input logic [BLUR_W-1:0] amount);
        cfg_valid <= 1'b1;
        cfg_data  <= amount;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid    <= 1'b0;
        blur_setting  = amount;
        cfg_writes++;
    endtask

    function automatic pix_in_t pix(input int r, input int g, input int b, input bit ls);
        pix_in_t px;
        px = {PIX_W'(r), PIX_W'(g), PIX_W'(b), ls};
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // No flag on the very first pixels: the empty window acts as a line start
    task automatic test_unflagged_first_line();
        send_pixel(pix(255, 255, 255, 1'b0));
        send_pixel(pix(0,   0,   0,   1'b0));
        send_pixel(pix(255, 0,   255, 1'b0));
        send_pixel(pix(1,   254, 128, 1'b0));
        drain_words();
    endtask

    // A flag mid-stream must throw the kept history away
    task automatic test_line_start_flush();
        send_pixel(pix(200, 100, 50,  1'b1));
        send_pixel(pix(255, 255, 255, 1'b0));
        drain_words();
    endtask

    // Zero amount: output is plain half source despite pixels kept in the history
    task automatic test_zero_blur();
        write_blur(BLUR_W'(0));
        send_pixel(pix(255, 255, 255, 1'b0));
        send_pixel(pix(7,   8,   9,   1'b0));
        drain_words();
    endtask

    // Largest code, far above the ring depth
    task automatic test_oversized_blur();
        write_blur('1);
        send_pixel(pix(255, 0,   255, 1'b1));
        send_pixel(pix(0,   255, 0,   1'b0));
        send_pixel(pix(255, 255, 255, 1'b0));
        send_pixel(pix(0,   0,   0,   1'b0));
        drain_words();
    endtask

    // Shrink then widen the window without starting a new line
    task automatic test_blur_change_mid_line();
        write_blur(BLUR_W'(2));
        send_pixel(pix(10,  20,  30,  1'b0));
        send_pixel(pix(255, 255, 255, 1'b0));
        drain_words();
        write_blur(BLUR_W'(WIN_MAX));
        send_pixel(pix(128, 128, 128, 1'b0));
        send_pixel(pix(3,   5,   7,   1'b0));
        drain_words();
    endtask

    // Hold the output off for a long stretch while pixels keep coming, so the
    // block backs up and drops s_ready; then pause the input until all is out.
    task automatic test_output_holdoff();
        int unsigned k;
        src_idle_pct   = 0;
        snk_stall_pct <= 0;
        holdoff_asked <= holdoff_asked + 1;
        for (k = 0; k < 8; k++) begin
            send_pixel(shade(TONE_ANY, '0) | pix_in_t'(k == 0));
        end
        drain_words();
    endtask

    // ------------------------------------------------------------------------
    // Random lines
    // ------------------------------------------------------------------------

    // Mostly well-formed lines long enough to fill the ring; some ragged ones
    // with stray flags, and some that carry on the previous line unflagged.
    task automatic run_segment(input int unsigned n_words);
        int unsigned left;
        int unsigned len;
        int unsigned k;
        int unsigned pick;
        bit          ragged;
        bit          carry_on;
        tone_t       tone;
        logic [23:0] base;
        pix_in_t     px;
        left = n_words;
        while (left != 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 40);
            if (len > left) begin
                len = left;
            end
            ragged   = ($urandom_range(99) < 15);
            carry_on = ($urandom_range(99) < 10);
            pick     = $urandom_range(9);
            tone     = (pick < 6) ? TONE_ANY : (pick < 8) ? TONE_RAIL : TONE_NEAR;
            base     = 24'($urandom);
            for (k = 0; k < len; k++) begin
                px = shade(tone, base);
                if (ragged) begin
                    px.line_start = ($urandom_range(4) == 0);
                end else begin
                    px.line_start = (k == 0) && !carry_on;
                end
                send_pixel(px);
            end
            lines_sent++;
            left -= len;
        end
    endtask

    // Four flow-control phases; the blur amount moves between segments, sometimes
    // leaving a line open across the change.
    task automatic test_random_phases();
        int unsigned src_pcts [4] = '{0, 80, 0, 13};
        int unsigned snk_pcts [4] = '{0, 0, 80, 13};
        int unsigned p;
        int unsigned s;
        for (p = 0; p < 4; p++) begin
            src_idle_pct   = src_pcts[p];
            snk_stall_pct <= snk_pcts[p];
            for (s = 0; s < SEGS_PER_PHASE; s++) begin
                drain_words();
                case (s)
                    0:       write_blur(BLUR_W'(WIN_MAX));
                    2:       write_blur(p[0] ? '1 : '0);
                    default: write_blur(BLUR_W'($urandom_range(31)));
                endcase
                run_segment(WORDS_PER_SEG);
            end
        end
        drain_words();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unflagged_first_line();
        test_line_start_flush();
        test_zero_blur();
        test_oversized_blur();
        test_blur_change_mid_line();
        test_output_holdoff();
        test_random_phases();

        drain_words();
        repeat (END_SETTLE) @(posedge aclk);
        if (blurred_q.size() != 0) begin
            fail_cnt += blurred_q.size();
            $display("%0d predicted words never came out", blurred_q.size());
        end

        $display("Checked %0d blurred words from %0d pixels in %0d random lines, %0d blur writes.",
                 words_checked, pixels_sent, lines_sent, cfg_writes);
        $display("Flow control: free-running, starved, back-pressured, mixed, and a %0d-cycle hold-off.",
                 HOLDOFF_CYCLES);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", fail_cnt);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, set far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Watchdog expired with %0d words outstanding", blurred_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
